// ===== hdl/dds_sine_generator_top_defines.svh =====
// Assertion macros shared by the checker file of the sine generator.
// Depends on nothing; expects signals named clock and reset in the scope of use.
`ifndef DDS_SINE_GENERATOR_TOP_DEFINES_SVH
`define DDS_SINE_GENERATOR_TOP_DEFINES_SVH

// Concurrent assertion sampled on clock, switched off while reset is high.
`define DDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define DDS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/dds_pkg.sv =====
// Package for the DDS sine generator: widths, register map, reset values
// and the elaboration-time quarter-wave sine function. Depends on nothing.
package dds_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int DAC_BITS_DEFAULT        = 12;

   localparam int TUNING_BITS    = 32;
   localparam int SNAP_BITS      = 32;
   localparam int SINE_FRAC_BITS = 15;
   localparam int REQ_DATA_BITS  = 8;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_TUNING_WORD    = 2'd0;
   localparam logic [1:0] REG_DC_OFFSET      = 2'd1;
   localparam logic [1:0] REG_AMPLITUDE_CODE = 2'd2;

   localparam int BIAS_RESET      = 1613;
   localparam int AMPLITUDE_RESET = 620;

   localparam logic [63:0] HALF_PI_Q62 = 64'd7244019458077122842;
   localparam logic [63:0] LO32        = 64'h0000_0000_ffff_ffff;

   // (a*b) >> 62, a and b below 2^63
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] a0, a1, b0, b1;
      logic [63:0] p00, p01, p10, p11;
      logic [63:0] mid, hi, lo;
      a0  = a & LO32;
      a1  = a >> 32;
      b0  = b & LO32;
      b1  = b >> 32;
      p00 = a0 * b0;
      p01 = a0 * b1;
      p10 = a1 * b0;
      p11 = a1 * b1;
      mid = (p00 >> 32) + (p01 & LO32) + (p10 & LO32);
      hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
      lo  = (mid << 32) | (p00 & LO32);
      return (hi << 2) | (lo >> 62);
   endfunction

   // unsigned quotient by restoring shift-subtract; divisor is small here
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rmd;
      quo = '0;
      rmd = '0;
      for (int i = 63; i >= 0; i--) begin
         rmd = {rmd[62:0], num[i]};
         if (rmd >= den) begin
            rmd    = rmd - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(pi/2 * j / 2^qbits) as a rounded Q0.15 magnitude, saturated at 32767.
   // Only evaluated at elaboration to fill the constant table.
   function automatic logic [SINE_FRAC_BITS-1:0] quarter_sine(input logic [63:0] j,
                                                              input int qbits);
      logic [63:0] hi, lo, x, x2, term, sum, r, den;
      hi   = HALF_PI_Q62 >> qbits;
      lo   = HALF_PI_Q62 & ((64'd1 << qbits) - 64'd1);
      x    = hi * j + ((lo * j) >> qbits);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 24; k++) begin
         if (term != 64'd0) begin
            den  = 64'(2 * k) * 64'(2 * k + 1);
            term = div_u64(mul_q62(term, x2), den);
            if (k[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      r = (sum + (64'd1 << 46)) >> 47;
      return (r > 64'd32767) ? SINE_FRAC_BITS'(32767) : r[SINE_FRAC_BITS-1:0];
   endfunction

endpackage

// ===== hdl/dds_sine_generator_top.sv =====
// DDS sine generator top level: phase accumulator, quarter-wave sine table,
// amplitude scaling, offset and clamp, with an APB-style register port.
// Depends on dds_pkg.
//
// Each accepted request transaction is one DAC sample tick. The block takes one
// transaction per clock while the response side keeps up, and returns one
// response transaction per request. The accepting edge loads the input
// register; the next edge with room loads the result register, which drives
// rsp_tvalid, and the response is taken at an edge with rsp_tready high. The
// per-sample rate is set by the phase accumulator, a single PHASE_BITS-wide add
// that closes on itself each cycle; the table read, the 15 x DAC_BITS multiply
// and the offset/clamp form one combinational pass between the input register
// and the result register. Backpressure on rsp_tready holds the result register,
// and a request is still taken while the result register is full as long as the
// input register is empty.
// req_tdata bit 0 is capture: when set, the phase before this step is copied to
// the snapshot register, and every response carries the most recent snapshot.
// Registers (byte address): 0x0 tuning_word, 0x4 dc_offset, 0x8 amplitude_code.
// Write them only while no sample is in flight. The sine table holds one
// quarter wave of 2^(TABLE_ADDR_BITS-2) entries plus a separate peak constant,
// all computed at elaboration; the rest of the wave comes from symmetry.
module dds_sine_generator_top #(
   parameter int PHASE_BITS      = dds_pkg::PHASE_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = dds_pkg::TABLE_ADDR_BITS_DEFAULT,
   parameter int DAC_BITS        = dds_pkg::DAC_BITS_DEFAULT,
   localparam int RSP_DATA_BITS  = ((DAC_BITS + dds_pkg::SNAP_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dds_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dds_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dds_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dds_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // [0] capture, rest zero
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_DATA_BITS-1:0]           rsp_tdata    // sample_code, snapshot_phase
);

   localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam int FRAC         = dds_pkg::SINE_FRAC_BITS;
   localparam int PROD_BITS    = FRAC + DAC_BITS;
   localparam int SNAP         = dds_pkg::SNAP_BITS;
   localparam logic [FRAC-1:0] SINE_PEAK =
      dds_pkg::quarter_sine(64'(QUARTER_LEN), QUARTER_BITS);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [dds_pkg::TUNING_BITS-1:0] tuning_ff;
   logic [DAC_BITS-1:0]             bias_ff;
   logic [DAC_BITS-1:0]             amplitude_ff;
   logic                            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_ff    <= '0;
         bias_ff      <= DAC_BITS'(dds_pkg::BIAS_RESET);
         amplitude_ff <= DAC_BITS'(dds_pkg::AMPLITUDE_RESET);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            dds_pkg::REG_TUNING_WORD:    tuning_ff    <= csr_pwdata[dds_pkg::TUNING_BITS-1:0];
            dds_pkg::REG_DC_OFFSET:      bias_ff      <= csr_pwdata[DAC_BITS-1:0];
            dds_pkg::REG_AMPLITUDE_CODE: amplitude_ff <= csr_pwdata[DAC_BITS-1:0];
            default: ;  // unmapped address: write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         dds_pkg::REG_TUNING_WORD:    csr_prdata = dds_pkg::CSR_DATA_BITS'(tuning_ff);
         dds_pkg::REG_DC_OFFSET:      csr_prdata = dds_pkg::CSR_DATA_BITS'(bias_ff);
         dds_pkg::REG_AMPLITUDE_CODE: csr_prdata = dds_pkg::CSR_DATA_BITS'(amplitude_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake: input register moves when it is empty or the result register has room
   // ------------------------------------------------------------------
   logic va_ff, vc_ff;
   logic ready_a, ready_c;
   logic req_accept;

   assign ready_c    = ~vc_ff | rsp_tready;
   assign ready_a    = ~va_ff | ready_c;
   assign req_tready = ready_a;
   assign req_accept = req_tvalid & ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) va_ff <= req_tvalid;
         if (ready_c) vc_ff <= va_ff;
      end
   end

   // ------------------------------------------------------------------
   // Input register: phase accumulator and capture
   // ------------------------------------------------------------------
   logic [PHASE_BITS-1:0]      phase_ff;
   logic [PHASE_BITS-1:0]      phase_in;
   logic [PHASE_BITS-1:0]      captured_ff;
   logic                       capture;
   logic [TABLE_ADDR_BITS-1:0] idx_a_ff;
   logic [SNAP-1:0]            snap_a_ff;

   assign capture  = req_tdata[0];
   assign phase_in = phase_ff + PHASE_BITS'(tuning_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         captured_ff <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         if (capture) captured_ff <= phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_a_ff  <= phase_in[PHASE_BITS-1 -: TABLE_ADDR_BITS];
         snap_a_ff <= capture ? SNAP'(phase_ff) : SNAP'(captured_ff);
      end
   end

   // ------------------------------------------------------------------
   // Quarter-wave table lookup and amplitude multiply
   // ------------------------------------------------------------------
   logic [FRAC-1:0]         sine_rom [QUARTER_LEN];
   logic [1:0]              quad;
   logic [QUARTER_BITS-1:0] rem;
   logic [QUARTER_BITS-1:0] rom_addr;
   logic                    mirror;
   logic [FRAC-1:0]         mag;
   logic [PROD_BITS-1:0]    prod_in;

   for (genvar g = 0; g < QUARTER_LEN; g++) begin : g_rom
      localparam logic [FRAC-1:0] ENTRY = dds_pkg::quarter_sine(64'(g), QUARTER_BITS);
      assign sine_rom[g] = ENTRY;
   end

   assign quad     = idx_a_ff[TABLE_ADDR_BITS-1 -: 2];
   assign rem      = idx_a_ff[QUARTER_BITS-1:0];
   assign mirror   = quad[0];
   // odd quadrants run the quarter wave backwards; their first point is the peak
   assign rom_addr = mirror ? (~rem + QUARTER_BITS'(1)) : rem;
   assign mag      = (mirror && rem == '0) ? SINE_PEAK : sine_rom[rom_addr];
   assign prod_in  = PROD_BITS'(mag) * PROD_BITS'(amplitude_ff);

   // ------------------------------------------------------------------
   // Offset, clamp, result register
   // ------------------------------------------------------------------
   logic [DAC_BITS-1:0] scaled;
   logic [DAC_BITS:0]   sum_pos;
   logic [DAC_BITS-1:0] code_in;
   logic [DAC_BITS-1:0] code_c_ff;
   logic [SNAP-1:0]     snap_c_ff;

   assign scaled  = prod_in[PROD_BITS-1 -: DAC_BITS];  // >> 15, truncates toward zero
   assign sum_pos = {1'b0, bias_ff} + {1'b0, scaled};

   always_comb begin
      if (quad[1]) begin
         code_in = (scaled > bias_ff) ? '0 : (bias_ff - scaled);
      end else begin
         code_in = sum_pos[DAC_BITS] ? '1 : sum_pos[DAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (va_ff && ready_c) begin
         code_c_ff <= code_in;
         snap_c_ff <= snap_a_ff;
      end
   end

   assign rsp_tvalid = vc_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({snap_c_ff, code_c_ff});

endmodule

// ===== hdl/dds_checker.sv =====
// Port-level checker for the DDS sine generator, attached by bind.
// Depends on dds_pkg and dds_sine_generator_top_defines.svh.
`include "dds_sine_generator_top_defines.svh"

module dds_checker #(
   parameter int DAC_BITS       = dds_pkg::DAC_BITS_DEFAULT,
   localparam int RSP_DATA_BITS = ((DAC_BITS + dds_pkg::SNAP_BITS + 7) / 8) * 8
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [dds_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [dds_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [dds_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                               csr_pready,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [RSP_DATA_BITS-1:0]           rsp_tdata    // sample_code, snapshot_phase
);

   logic csr_wr;
   logic tuning_wr;
   logic tuning_rd;

   assign csr_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign tuning_wr = csr_wr & (csr_paddr[3:2] == dds_pkg::REG_TUNING_WORD);
   assign tuning_rd = ~csr_wr & (csr_paddr[3:2] == dds_pkg::REG_TUNING_WORD);

   // stalled response holds its payload
   `DDS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // reset empties the pipe
   `DDS_ASSERT_RST(a_reset_empty, $past(reset) |-> !rsp_tvalid, "response valid right after reset")

   // with the result register empty the whole pipe has room
   `DDS_ASSERT(a_empty_ready, !rsp_tvalid |-> req_tready, "request stalled with empty output")

   // tuning word reads back what was last written
   `DDS_ASSERT(a_tuning_readback, tuning_wr ##1 tuning_rd |-> csr_prdata == $past(csr_pwdata), "tuning word readback mismatch")

endmodule

bind dds_sine_generator_top dds_checker #(.DAC_BITS(DAC_BITS)) u_dds_checker (.*);
